>>> src/wfpid_pkg.sv
// ----------------------------------------------------------------------------
// wfpid_pkg
// Types and constants shared by the wall-follow PID turn controller.
// ----------------------------------------------------------------------------
package wfpid_pkg;

  typedef enum logic [1:0] {
    MODE_SEARCH = 2'd0,
    MODE_LEFT   = 2'd1,
    MODE_RIGHT  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CFG_SIDE_THR   = 3'd0,
    CFG_MIN_DIST   = 3'd1,
    CFG_DES_DIST   = 3'd2,
    CFG_MAX_DIST   = 3'd3,
    CFG_GAIN_P     = 3'd4,
    CFG_GAIN_D     = 3'd5,
    CFG_GAIN_I     = 3'd6,
    CFG_SPIN_SPEED = 3'd7
  } cfg_idx_t;

  localparam int DIST_W   = 10;
  localparam int HEAD_W   = 16;
  localparam int CORR_W   = 9;
  localparam int DRIVE_W  = 10;
  localparam int ERR_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam int INTEG_LIM    = 800;
  localparam int DRIVE_LIM    = 200;
  localparam int HEAD_ERR_MIN = 2;

  localparam logic [9:0] RST_SIDE_THR   = 10'd100;
  localparam logic [9:0] RST_MIN_DIST   = 10'd10;
  localparam logic [9:0] RST_DES_DIST   = 10'd150;
  localparam logic [9:0] RST_MAX_DIST   = 10'd400;
  localparam logic [3:0] RST_GAIN_P     = 4'd4;
  localparam logic [3:0] RST_GAIN_D     = 4'd10;
  localparam logic [7:0] RST_GAIN_I     = 8'd8;
  localparam logic [7:0] RST_SPIN_SPEED = 8'd100;

  typedef struct packed {
    logic [9:0] side_thr;
    logic [9:0] min_dist;
    logic [9:0] des_dist;
    logic [9:0] max_dist;
    logic [3:0] gain_p;
    logic [3:0] gain_d;
    logic [7:0] gain_i;
    logic [7:0] spin_speed;
  } cfg_t;

  typedef struct packed {
    logic signed [9:0]  drive;
    logic signed [10:0] integ;
    logic signed [10:0] err;
  } pid_res_t;

endpackage

>>> src/wfpid_in_if.sv
// ----------------------------------------------------------------------------
// wfpid_in_if
// Sensor tick request channel.
// ----------------------------------------------------------------------------
interface wfpid_in_if;
  logic               valid;
  logic               ready;
  logic [9:0]         right_wall_dist;
  logic [9:0]         left_wall_dist;
  logic [9:0]         front_left_dist;
  logic [9:0]         front_right_dist;
  logic signed [15:0] heading;
  logic signed [15:0] heading_error;
  logic signed [8:0]  heading_correction;

  modport source (
    output valid, right_wall_dist, left_wall_dist, front_left_dist, front_right_dist,
           heading, heading_error, heading_correction,
    input  ready
  );
  modport sink (
    input  valid, right_wall_dist, left_wall_dist, front_left_dist, front_right_dist,
           heading, heading_error, heading_correction,
    output ready
  );
endinterface

>>> src/wfpid_out_if.sv
// ----------------------------------------------------------------------------
// wfpid_out_if
// Drive result request channel.
// ----------------------------------------------------------------------------
interface wfpid_out_if;
  logic               valid;
  logic               ready;
  logic signed [9:0]  left_drive;
  logic signed [9:0]  right_drive;
  logic [1:0]         mode_now;
  logic               turn_started;
  logic signed [15:0] turn_setpoint;

  modport source (
    output valid, left_drive, right_drive, mode_now, turn_started, turn_setpoint,
    input  ready
  );
  modport sink (
    input  valid, left_drive, right_drive, mode_now, turn_started, turn_setpoint,
    output ready
  );
endinterface

>>> src/wfpid_cfg_if.sv
// ----------------------------------------------------------------------------
// wfpid_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
interface wfpid_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [9:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/wall_follow_pid_turn_controller.sv
// ----------------------------------------------------------------------------
// wall_follow_pid_turn_controller
// Wall-follow drive controller: two front-distance PID loops and turn states.
//
// Channels: in_ch takes one sensor tick per request, out_ch gives one drive
// request per tick, cfg_ch writes the eight configuration registers (always
// ready, one write per cycle). The user must write only while the block is
// idle; the block does not enforce it. A tick is captured in the input
// register, then processed by the combinational state update (PID
// multiply-add and turn compare) into the result register, which offers it.
// One tick per cycle is taken while out_ch is ready.
// Stall: a held result keeps the input register filled; one further tick is
// accepted and waits there, after which in_ch.ready drops until out_ch moves.
// Reset (rst_n low, synchronous): mode searching, loop state, drives and
// turn setpoint zero, registers at their defaults, both registers empty.
// ----------------------------------------------------------------------------
module wall_follow_pid_turn_controller #(
  parameter int LEFT_TURN_ANGLE  = 90,
  parameter int RIGHT_TURN_ANGLE = 90
) (
  input  logic          clk,
  input  logic          rst_n,
  wfpid_in_if.sink      in_ch,
  wfpid_out_if.source   out_ch,
  wfpid_cfg_if.sink     cfg_ch
);
  import wfpid_pkg::*;

  localparam int CMP_W = HEAD_W + 2;

  cfg_t cfg_r;

  logic               in_vld_r;
  logic [9:0]         rwd_r, lwd_r, fld_r, frd_r;
  logic signed [15:0] head_r, herr_r;
  logic signed [8:0]  corr_r;

  logic               out_vld_r;
  logic               started_r, started_nxt;
  mode_t              mode_r, mode_nxt;
  logic signed [10:0] li_r, li_nxt, ri_r, ri_nxt;
  logic signed [10:0] lp_r, lp_nxt, rp_r, rp_nxt;
  logic signed [15:0] start_head_r, start_head_nxt;
  logic [15:0]        target_r, target_nxt;
  logic signed [9:0]  ldrv_r, ldrv_nxt, rdrv_r, rdrv_nxt;

  logic     out_load, in_fire;
  pid_res_t lpid, rpid;
  logic signed [9:0] turn_a, turn_b;
  logic     left_done, right_done;

  function automatic pid_res_t pid_side(input logic [9:0] rng,
                                        input logic signed [10:0] integ,
                                        input logic signed [10:0] prev,
                                        input cfg_t c);
    pid_res_t           r;
    logic [9:0]         d;
    logic signed [10:0] e;
    logic signed [10:0] iu;
    logic signed [19:0] iprod;
    logic signed [19:0] ctl;
    logic signed [11:0] isum;
    d  = (rng < c.min_dist) ? '0 : rng;
    e  = $signed({1'b0, d}) - $signed({1'b0, c.des_dist});
    iu = integ;
    if (d > c.max_dist) begin
      e  = '0;
      iu = '0;
    end
    iprod = 20'($signed({1'b0, c.gain_i})) * 20'(iu);
    ctl   = 20'($signed({1'b0, c.gain_p})) * 20'(e)
          + 20'($signed({1'b0, c.gain_d})) * (20'(e) - 20'(prev))
          + (iprod >>> 8);
    if (ctl > 20'(DRIVE_LIM)) begin
      r.drive = 10'(DRIVE_LIM);
    end else if (ctl < 20'(-DRIVE_LIM)) begin
      r.drive = 10'(-DRIVE_LIM);
    end else begin
      r.drive = ctl[9:0];
    end
    isum = 12'(iu) + 12'(e);
    if (isum > 12'(INTEG_LIM)) begin
      r.integ = 11'(INTEG_LIM);
    end else if (isum < 12'(-INTEG_LIM)) begin
      r.integ = 11'(-INTEG_LIM);
    end else begin
      r.integ = isum[10:0];
    end
    r.err = e;
    return r;
  endfunction

  // handshake
  assign out_load     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || out_load;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.side_thr   <= RST_SIDE_THR;
      cfg_r.min_dist   <= RST_MIN_DIST;
      cfg_r.des_dist   <= RST_DES_DIST;
      cfg_r.max_dist   <= RST_MAX_DIST;
      cfg_r.gain_p     <= RST_GAIN_P;
      cfg_r.gain_d     <= RST_GAIN_D;
      cfg_r.gain_i     <= RST_GAIN_I;
      cfg_r.spin_speed <= RST_SPIN_SPEED;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_SIDE_THR:   cfg_r.side_thr   <= cfg_ch.data;
        CFG_MIN_DIST:   cfg_r.min_dist   <= cfg_ch.data;
        CFG_DES_DIST:   cfg_r.des_dist   <= cfg_ch.data;
        CFG_MAX_DIST:   cfg_r.max_dist   <= cfg_ch.data;
        CFG_GAIN_P:     cfg_r.gain_p     <= cfg_ch.data[3:0];
        CFG_GAIN_D:     cfg_r.gain_d     <= cfg_ch.data[3:0];
        CFG_GAIN_I:     cfg_r.gain_i     <= cfg_ch.data[7:0];
        CFG_SPIN_SPEED: cfg_r.spin_speed <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_fire) begin
      in_vld_r <= 1'b1;
    end else if (out_load) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rwd_r  <= in_ch.right_wall_dist;
      lwd_r  <= in_ch.left_wall_dist;
      fld_r  <= in_ch.front_left_dist;
      frd_r  <= in_ch.front_right_dist;
      head_r <= in_ch.heading;
      herr_r <= in_ch.heading_error;
      corr_r <= in_ch.heading_correction;
    end
  end

  assign lpid   = pid_side(fld_r, li_r, lp_r, cfg_r);
  assign rpid   = pid_side(frd_r, ri_r, rp_r, cfg_r);
  assign turn_a = 10'(corr_r) - 10'($signed({1'b0, cfg_r.spin_speed}));
  assign turn_b = 10'($signed({1'b0, cfg_r.spin_speed})) - 10'(corr_r);

  assign left_done  = CMP_W'(start_head_r) + CMP_W'(LEFT_TURN_ANGLE) <= CMP_W'(head_r);
  assign right_done = (herr_r > 16'(HEAD_ERR_MIN) || herr_r < 16'(-HEAD_ERR_MIN))
                   && (CMP_W'(start_head_r) + CMP_W'(RIGHT_TURN_ANGLE) <= CMP_W'(head_r));

  always_comb begin
    mode_nxt       = mode_r;
    li_nxt         = li_r;
    ri_nxt         = ri_r;
    lp_nxt         = lp_r;
    rp_nxt         = rp_r;
    start_head_nxt = start_head_r;
    target_nxt     = target_r;
    ldrv_nxt       = ldrv_r;
    rdrv_nxt       = rdrv_r;
    started_nxt    = 1'b0;
    unique case (mode_r)
      MODE_SEARCH: begin
        if (rwd_r <= cfg_r.side_thr) begin
          // right turn advances the setpoint by twice its angle
          target_nxt     = target_r + 16'(2 * RIGHT_TURN_ANGLE);
          mode_nxt       = MODE_RIGHT;
          start_head_nxt = head_r;
          started_nxt    = 1'b1;
        end else if (lwd_r <= cfg_r.side_thr) begin
          target_nxt     = target_r + 16'(LEFT_TURN_ANGLE);
          mode_nxt       = MODE_LEFT;
          start_head_nxt = head_r;
          started_nxt    = 1'b1;
        end else begin
          ldrv_nxt = lpid.drive;
          li_nxt   = lpid.integ;
          lp_nxt   = lpid.err;
          rdrv_nxt = rpid.drive;
          ri_nxt   = rpid.integ;
          rp_nxt   = rpid.err;
        end
      end
      MODE_LEFT: begin
        if (left_done) begin
          mode_nxt       = MODE_SEARCH;
          start_head_nxt = '0;
        end
        ldrv_nxt = turn_a;
        rdrv_nxt = turn_b;
      end
      MODE_RIGHT: begin
        if (right_done) begin
          mode_nxt       = MODE_SEARCH;
          start_head_nxt = '0;
        end
        ldrv_nxt = turn_b;
        rdrv_nxt = turn_a;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r    <= 1'b0;
      started_r    <= 1'b0;
      mode_r       <= MODE_SEARCH;
      li_r         <= '0;
      ri_r         <= '0;
      lp_r         <= '0;
      rp_r         <= '0;
      start_head_r <= '0;
      target_r     <= '0;
      ldrv_r       <= '0;
      rdrv_r       <= '0;
    end else begin
      if (out_load) begin
        out_vld_r    <= 1'b1;
        started_r    <= started_nxt;
        mode_r       <= mode_nxt;
        li_r         <= li_nxt;
        ri_r         <= ri_nxt;
        lp_r         <= lp_nxt;
        rp_r         <= rp_nxt;
        start_head_r <= start_head_nxt;
        target_r     <= target_nxt;
        ldrv_r       <= ldrv_nxt;
        rdrv_r       <= rdrv_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.left_drive    = ldrv_r;
  assign out_ch.right_drive   = rdrv_r;
  assign out_ch.mode_now      = mode_r;
  assign out_ch.turn_started  = started_r;
  assign out_ch.turn_setpoint = target_r;

  a_held_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !out_load |=> in_vld_r)
    else $error("pending tick dropped");

  a_start_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && started_r |-> mode_r != MODE_SEARCH)
    else $error("turn start without turn mode");

  a_integ_lim: assert property (@(posedge clk) disable iff (!rst_n)
    li_r <= 11'(INTEG_LIM) && li_r >= 11'(-INTEG_LIM)
    && ri_r <= 11'(INTEG_LIM) && ri_r >= 11'(-INTEG_LIM))
    else $error("integral outside limit");

  a_turn_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && mode_r != MODE_SEARCH && mode_nxt == MODE_SEARCH |=> start_head_r == '0)
    else $error("start heading not cleared at turn end");

  a_drive_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && started_nxt |=> $stable(ldrv_r) && $stable(rdrv_r))
    else $error("drives changed on turn start");

endmodule

>>> tb/sv/tb_wall_follow_pid_turn_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wall_follow_pid_turn_controller
// Self-checking bench for the wall-follow PID turn controller. A directed
// table covers reset outputs, turn start and end (right turn setpoint step,
// held drives, unwrapped heading test, heading error gate), front-distance
// limits and saturation. Random sensor ticks follow over several register
// settings, extremes included, with bursty requests and a stalling receiver.
// Each drive request is checked against the table or an in-bench controller model.
// ----------------------------------------------------------------------------
module tb_wall_follow_pid_turn_controller;
  import wfpid_pkg::*;

  localparam int LEFT_ANGLE      = 90;
  localparam int RIGHT_ANGLE     = 90;
  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 235;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int SHOW_LIMIT      = 10;

  typedef struct packed {
    logic [9:0]         right_wall;
    logic [9:0]         left_wall;
    logic [9:0]         front_left;
    logic [9:0]         front_right;
    logic signed [15:0] heading;
    logic signed [15:0] heading_error;
    logic signed [8:0]  corr;
  } tick_t;

  typedef struct packed {
    logic signed [9:0]  left_drive;
    logic signed [9:0]  right_drive;
    mode_t              mode;
    logic               started;
    logic signed [15:0] setpoint;
  } drive_pair_t;

  typedef struct {
    tick_t       stim;
    bit          typed;
    drive_pair_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  wfpid_in_if  tick_bus ();
  wfpid_out_if drive_bus ();
  wfpid_cfg_if reg_bus ();

  wall_follow_pid_turn_controller #(
    .LEFT_TURN_ANGLE  (LEFT_ANGLE),
    .RIGHT_TURN_ANGLE (RIGHT_ANGLE)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (tick_bus),
    .out_ch (drive_bus),
    .cfg_ch (reg_bus)
  );

  // controller model state
  cfg_t        cur_cfg;
  mode_t       pred_mode;
  int          loop_integ [2];
  int          loop_prev [2];
  int          start_hdg;
  logic [15:0] setpoint;
  int          left_drv;
  int          right_drv;

  drive_pair_t pending_drives [$];
  dir_row_t    dir_rows [$];
  drive_pair_t seen_want;

  int fail_count;
  int cycle_count;
  int burst_left;
  int rx_style;
  int rx_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int clamp_to(input int x, input int lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic int front_pid(input int side, input logic [9:0] rng);
    int d;
    int e;
    int ctl;
    d = rng;
    if (d < int'(cur_cfg.min_dist)) d = 0;
    e = d - int'(cur_cfg.des_dist);
    if (d > int'(cur_cfg.max_dist)) begin
      e = 0;
      loop_integ[side] = 0;
    end
    ctl = int'(cur_cfg.gain_p) * e + int'(cur_cfg.gain_d) * (e - loop_prev[side])
        + ((int'(cur_cfg.gain_i) * loop_integ[side]) >>> 8);
    loop_prev[side] = e;
    loop_integ[side] = clamp_to(loop_integ[side] + e, INTEG_LIM);
    return clamp_to(ctl, DRIVE_LIM);
  endfunction

  function automatic drive_pair_t predict_drive(input tick_t t);
    drive_pair_t r;
    int hd;
    int he;
    int co;
    int spd;
    hd  = t.heading;
    he  = t.heading_error;
    co  = t.corr;
    spd = cur_cfg.spin_speed;
    r.started = 1'b0;
    case (pred_mode)
      MODE_SEARCH: begin
        if (t.right_wall <= cur_cfg.side_thr) begin
          setpoint  = setpoint + 16'(2 * RIGHT_ANGLE);
          pred_mode = MODE_RIGHT;
          start_hdg = hd;
          r.started = 1'b1;
        end else if (t.left_wall <= cur_cfg.side_thr) begin
          setpoint  = setpoint + 16'(LEFT_ANGLE);
          pred_mode = MODE_LEFT;
          start_hdg = hd;
          r.started = 1'b1;
        end else begin
          left_drv  = front_pid(0, t.front_left);
          right_drv = front_pid(1, t.front_right);
        end
      end
      MODE_LEFT: begin
        if (start_hdg + LEFT_ANGLE <= hd) begin
          pred_mode = MODE_SEARCH;
          start_hdg = 0;
        end
        left_drv  = co - spd;
        right_drv = spd - co;
      end
      MODE_RIGHT: begin
        if ((he > HEAD_ERR_MIN || he < -HEAD_ERR_MIN) && start_hdg + RIGHT_ANGLE <= hd) begin
          pred_mode = MODE_SEARCH;
          start_hdg = 0;
        end
        left_drv  = spd - co;
        right_drv = co - spd;
      end
      default: ;
    endcase
    r.left_drive  = left_drv[9:0];
    r.right_drive = right_drv[9:0];
    r.mode        = pred_mode;
    r.setpoint    = setpoint;
    return r;
  endfunction

  function automatic logic [9:0] clear_of_wall(input int thr);
    if (thr >= 1023) return 10'd1023;
    return 10'($urandom_range(thr + 1, 1023));
  endfunction

  function automatic logic [9:0] front_dist();
    int v;
    case ($urandom_range(0, 5))
      0: v = int'($urandom_range(0, 1023));
      1: v = int'(cur_cfg.des_dist) + int'($urandom_range(0, 120)) - 60;
      2: v = int'(cur_cfg.min_dist) + int'($urandom_range(0, 2)) - 1;
      3: v = int'(cur_cfg.max_dist) + int'($urandom_range(0, 2)) - 1;
      default: v = int'(cur_cfg.des_dist) + int'($urandom_range(0, 300));
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[9:0];
  endfunction

  // well-formed ticks against the current model state, some noise mixed in
  function automatic tick_t random_tick();
    tick_t t;
    int thr;
    int hd;
    int he;
    int co;
    int ang;
    int tgt;
    int sel;
    thr = cur_cfg.side_thr;
    hd  = int'($urandom_range(0, 65535)) - 32768;
    if ($urandom_range(0, 1) == 1) he = int'($urandom_range(0, 10)) - 5;
    else he = int'($urandom_range(0, 65535)) - 32768;
    co = int'($urandom_range(0, 510)) - 255;
    t.front_left  = front_dist();
    t.front_right = front_dist();
    t.right_wall  = 10'($urandom_range(0, 1023));
    t.left_wall   = 10'($urandom_range(0, 1023));
    if (pred_mode == MODE_SEARCH) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        t.right_wall = 10'($urandom_range(0, thr));
      end else if (sel < 10) begin
        t.right_wall = clear_of_wall(thr);
        t.left_wall  = 10'($urandom_range(0, thr));
      end else if (sel < 95) begin
        t.right_wall = clear_of_wall(thr);
        t.left_wall  = clear_of_wall(thr);
      end
      // a turn started too near the top of the heading range could never end
      if (t.right_wall <= cur_cfg.side_thr) ang = RIGHT_ANGLE;
      else if (t.left_wall <= cur_cfg.side_thr) ang = LEFT_ANGLE;
      else ang = 0;
      if (ang != 0 && hd + ang > 32767) hd = 32767 - ang - int'($urandom_range(0, 2000));
    end else begin
      ang = (pred_mode == MODE_LEFT) ? LEFT_ANGLE : RIGHT_ANGLE;
      tgt = start_hdg + ang;
      sel = $urandom_range(0, 7);
      if (sel < 2) hd = tgt + int'($urandom_range(0, 40));
      else if (sel == 2) hd = tgt - 1;
      else if (sel < 6) hd = tgt - int'($urandom_range(1, 500));
    end
    if (hd > 32767) hd = 32767;
    if (hd < -32768) hd = -32768;
    t.heading       = hd[15:0];
    t.heading_error = he[15:0];
    t.corr          = co[8:0];
    return t;
  endfunction

  task automatic add_row(input int rw, input int lw, input int fl, input int fr,
                         input int hd, input int he, input int co, input bit typed,
                         input int l = 0, input int r = 0, input int m = 0,
                         input int s = 0, input int sp = 0);
    dir_row_t row;
    row.stim.right_wall       = rw[9:0];
    row.stim.left_wall        = lw[9:0];
    row.stim.front_left       = fl[9:0];
    row.stim.front_right      = fr[9:0];
    row.stim.heading          = hd[15:0];
    row.stim.heading_error    = he[15:0];
    row.stim.corr             = co[8:0];
    row.typed                 = typed;
    row.want.left_drive       = l[9:0];
    row.want.right_drive      = r[9:0];
    row.want.mode             = mode_t'(m[1:0]);
    row.want.started          = s[0];
    row.want.setpoint         = sp[15:0];
    dir_rows.push_back(row);
  endtask

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= SHOW_LIMIT) $display("%s", msg);
  endtask

  task automatic send_tick(input tick_t t);
    @(negedge clk);
    tick_bus.valid              <= 1'b1;
    tick_bus.right_wall_dist    <= t.right_wall;
    tick_bus.left_wall_dist     <= t.left_wall;
    tick_bus.front_left_dist    <= t.front_left;
    tick_bus.front_right_dist   <= t.front_right;
    tick_bus.heading            <= t.heading;
    tick_bus.heading_error      <= t.heading_error;
    tick_bus.heading_correction <= t.corr;
    do @(posedge clk); while (tick_bus.ready !== 1'b1);
  endtask

  // bursts of requests with random gaps between them
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        tick_bus.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk);
    tick_bus.valid <= 1'b0;
    while (pending_drives.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [9:0] val);
    @(negedge clk);
    reg_bus.valid <= 1'b1;
    reg_bus.index <= idx;
    reg_bus.data  <= val;
    do @(posedge clk); while (reg_bus.ready !== 1'b1);
    case (idx)
      CFG_SIDE_THR:   cur_cfg.side_thr   = val;
      CFG_MIN_DIST:   cur_cfg.min_dist   = val;
      CFG_DES_DIST:   cur_cfg.des_dist   = val;
      CFG_MAX_DIST:   cur_cfg.max_dist   = val;
      CFG_GAIN_P:     cur_cfg.gain_p     = val[3:0];
      CFG_GAIN_D:     cur_cfg.gain_d     = val[3:0];
      CFG_GAIN_I:     cur_cfg.gain_i     = val[7:0];
      CFG_SPIN_SPEED: cur_cfg.spin_speed = val[7:0];
      default: ;
    endcase
  endtask

  // receiver stall pattern
  initial begin
    drive_bus.ready = 1'b0;
    rx_left = 0;
    forever begin
      @(negedge clk);
      if (rx_left == 0) begin
        rx_style = $urandom_range(0, 2);
        rx_left  = $urandom_range(5, 60);
      end
      rx_left--;
      case (rx_style)
        0: drive_bus.ready <= 1'b1;
        1: drive_bus.ready <= ($urandom_range(0, 1) == 1);
        default: drive_bus.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && drive_bus.valid === 1'b1 && drive_bus.ready === 1'b1) begin
      if (pending_drives.size() == 0) begin
        flag_error($sformatf("unexpected drive request: L=%0d R=%0d mode=%0d sp=%0d",
                             drive_bus.left_drive, drive_bus.right_drive,
                             drive_bus.mode_now, drive_bus.turn_setpoint));
      end else begin
        seen_want = pending_drives.pop_front();
        if (drive_bus.left_drive !== seen_want.left_drive ||
            drive_bus.right_drive !== seen_want.right_drive ||
            drive_bus.mode_now !== seen_want.mode ||
            drive_bus.turn_started !== seen_want.started ||
            drive_bus.turn_setpoint !== seen_want.setpoint) begin
          flag_error($sformatf({"drive mismatch: want L=%0d R=%0d mode=%0d start=%0b ",
                                "sp=%0d, got L=%0d R=%0d mode=%0d start=%0b sp=%0d"},
                               seen_want.left_drive, seen_want.right_drive,
                               seen_want.mode, seen_want.started, seen_want.setpoint,
                               drive_bus.left_drive, drive_bus.right_drive,
                               drive_bus.mode_now, drive_bus.turn_started,
                               drive_bus.turn_setpoint));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    tick_t       t;
    drive_pair_t want;
    logic [9:0]  val;

    rst_n                       = 1'b0;
    tick_bus.valid              = 1'b0;
    tick_bus.right_wall_dist    = '0;
    tick_bus.left_wall_dist     = '0;
    tick_bus.front_left_dist    = '0;
    tick_bus.front_right_dist   = '0;
    tick_bus.heading            = '0;
    tick_bus.heading_error      = '0;
    tick_bus.heading_correction = '0;
    reg_bus.valid               = 1'b0;
    reg_bus.index               = '0;
    reg_bus.data                = '0;
    fail_count                  = 0;
    cycle_count                 = 0;
    burst_left                  = 0;

    cur_cfg = {RST_SIDE_THR, RST_MIN_DIST, RST_DES_DIST, RST_MAX_DIST,
               RST_GAIN_P, RST_GAIN_D, RST_GAIN_I, RST_SPIN_SPEED};
    pred_mode     = MODE_SEARCH;
    loop_integ[0] = 0;
    loop_integ[1] = 0;
    loop_prev[0]  = 0;
    loop_prev[1]  = 0;
    start_hdg     = 0;
    setpoint      = '0;
    left_drv      = 0;
    right_drv     = 0;

    // rw, lw, fl, fr, heading, head error, corr, typed | L, R, mode, started, setpoint
    add_row(1023, 1023, 150, 150, 0, 0, 0, 1, 0, 0, MODE_SEARCH, 0, 0);
    add_row(100, 0, 0, 1023, 0, 0, 0, 1, 0, 0, MODE_RIGHT, 1, 180);
    add_row(1023, 1023, 0, 0, 90, 2, 0, 1, 100, -100, MODE_RIGHT, 0, 180);
    add_row(1023, 1023, 0, 0, 90, -32768, 255, 1, -155, 155, MODE_SEARCH, 0, 180);
    add_row(101, 100, 0, 0, -32768, 32767, -255, 1, -155, 155, MODE_LEFT, 1, 270);
    add_row(0, 0, 0, 0, -32679, 0, -255, 1, -355, 355, MODE_LEFT, 0, 270);
    add_row(0, 0, 0, 0, 32767, 0, 0, 1, -100, 100, MODE_SEARCH, 0, 270);
    add_row(1023, 1023, 9, 401, 0, 0, 0, 0);
    add_row(1023, 1023, 10, 400, 0, 0, 0, 0);
    add_row(1023, 1023, 1023, 0, 0, 0, 0, 0);
    repeat (4) add_row(1023, 1023, 400, 10, 0, 0, 0, 0);
    add_row(1023, 1023, 0, 400, 0, 0, 0, 0);
    add_row(0, 1023, 150, 150, 32677, 0, 0, 0);
    add_row(1023, 1023, 0, 0, -32768, 3, 0, 1, 100, -100, MODE_RIGHT, 0, 450);
    add_row(1023, 1023, 0, 0, 32767, -3, -255, 1, 355, -355, MODE_SEARCH, 0, 450);
    add_row(0, 0, 150, 150, -100, 0, 0, 0);
    add_row(1023, 1023, 0, 0, -10, 3, 1, 1, 99, -99, MODE_SEARCH, 0, 630);
    add_row(1023, 0, 0, 0, 32677, 0, 0, 1, 99, -99, MODE_LEFT, 1, 720);
    add_row(1023, 1023, 0, 0, 32766, 0, 128, 1, 28, -28, MODE_LEFT, 0, 720);
    add_row(1023, 1023, 0, 0, 32767, 0, 0, 1, -100, 100, MODE_SEARCH, 0, 720);
    add_row(1023, 1023, 150, 150, 0, 0, 0, 0);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      pace();
      send_tick(dir_rows[i].stim);
      want = predict_drive(dir_rows[i].stim);
      if (dir_rows[i].typed) want = dir_rows[i].want;
      pending_drives.push_back(want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain();
        for (int i = 0; i < 8; i++) begin
          if (p == 1) val = 10'h3ff;
          else if (p == 2) val = 10'h000;
          else begin
            case (cfg_idx_t'(i))
              CFG_SIDE_THR: val = 10'($urandom_range(0, 400));
              CFG_MIN_DIST: val = 10'($urandom_range(0, 200));
              default:      val = 10'($urandom_range(0, 1023));
            endcase
          end
          write_reg(cfg_idx_t'(i), val);
        end
        @(negedge clk);
        reg_bus.valid <= 1'b0;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 3 && n == ITEMS_PER_PHASE / 2) drain();
        pace();
        t = random_tick();
        send_tick(t);
        pending_drives.push_back(predict_drive(t));
      end
    end

    @(negedge clk);
    tick_bus.valid <= 1'b0;
    while (pending_drives.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/wfpid_pkg.sv
src/wfpid_in_if.sv
src/wfpid_out_if.sv
src/wfpid_cfg_if.sv
src/wall_follow_pid_turn_controller.sv
tb/sv/tb_wall_follow_pid_turn_controller.sv
